// ===== rtl/cta_pkg.sv =====
// ----------------------------------------------------------------------------
// CIGAR to aligned boundaries package
// Shared item types, character codes and default sizes for the boundary core.
// ----------------------------------------------------------------------------
package cta_pkg;

    localparam int DEFAULT_POSITION_BITS = 31;
    localparam int BOUNDARY_BITS         = 31;
    localparam int INDEX_BITS            = 8;
    localparam int CHAR_BITS             = 8;

    localparam logic [CHAR_BITS-1:0] CH_0       = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_9       = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_M       = 8'h4D;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_M = 8'h6D;
    localparam logic [CHAR_BITS-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_BITS-1:0] CH_X       = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_N       = 8'h4E;
    localparam logic [CHAR_BITS-1:0] CH_D       = 8'h44;
    localparam logic [CHAR_BITS-1:0] CH_I       = 8'h49;
    localparam logic [CHAR_BITS-1:0] CH_STAR    = 8'h2A;

    localparam logic ACTION_BEGIN = 1'b0;
    localparam logic ACTION_CHAR  = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [BOUNDARY_BITS-1:0] start_position;
        logic [CHAR_BITS-1:0]     cigar_char;
        logic                     end_of_cigar;
    } cigar_item_t;

    typedef struct packed {
        logic [BOUNDARY_BITS-1:0] boundary;
        logic [INDEX_BITS-1:0]    boundary_index;
        logic                     empty_read;
        logic                     last;
    } bound_item_t;

    typedef struct packed {
        bound_item_t res0;
        bound_item_t res1;
        logic        two;
    } bound_row_t;

endpackage

// ===== rtl/cigar_to_aligned_boundaries_core.sv =====
// ----------------------------------------------------------------------------
// CIGAR to aligned boundaries core
// Turns a read's start position and its CIGAR characters into block boundaries.
// ----------------------------------------------------------------------------
// One item is taken every cycle while a buffer row is free. A begin item sets
// the start position; each CIGAR character updates the length and boundary
// state in the same cycle and yields up to two results, which are written as
// one row into a two-row result buffer and delivered from it one per cycle
// while bound_stall is low, res0 before res1 when a row holds two results; the
// input stalls only while both rows hold undelivered results.
module cigar_to_aligned_boundaries_core #(
    parameter int POSITION_BITS = cta_pkg::DEFAULT_POSITION_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cigar_valid,
    output logic                  cigar_stall,
    input  cta_pkg::cigar_item_t  cigar_item,
    output logic                  bound_valid,
    input  logic                  bound_stall,
    output cta_pkg::bound_item_t  bound_item
);

    localparam int PB = POSITION_BITS;
    localparam int BB = cta_pkg::BOUNDARY_BITS;
    localparam int EW = (PB > BB) ? PB : BB;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
    localparam logic [cta_pkg::INDEX_BITS-1:0] INDEX_MAX = {cta_pkg::INDEX_BITS{1'b1}};

    logic [PB-1:0]                  held_reg, held_next;
    logic [PB-1:0]                  run_reg, run_next;
    logic                           ins_reg, ins_next;
    logic [cta_pkg::INDEX_BITS-1:0] count_reg, count_next;
    logic                           star_reg, star_next;

    cta_pkg::bound_row_t rows_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          fill_reg, fill_next;
    logic                sel_reg, sel_next;

    logic                cigar_accept;
    logic                bound_accept;
    logic                pop;
    logic                push;
    cta_pkg::bound_row_t row_new;
    cta_pkg::bound_row_t head;

    logic [PB+3:0] acc_wide;
    logic [PB-1:0] run_digit;
    logic [PB:0]   sum_wide;
    logic [PB-1:0] sum_sat;
    logic [EW-1:0] start_wide;
    logic [PB-1:0] start_sat;
    logic [EW-1:0] held_wide;
    logic [EW-1:0] held_next_wide;

    logic [cta_pkg::CHAR_BITS-1:0] c;
    logic is_digit, is_match, is_gap, is_ins, is_star;
    logic append;

    assign cigar_stall  = (fill_reg == 2'd2);
    assign cigar_accept = cigar_valid && !cigar_stall;
    assign bound_valid  = (fill_reg != 2'd0);
    assign bound_accept = bound_valid && !bound_stall;

    assign head       = rows_reg[rd_ptr_reg];
    assign bound_item = sel_reg ? head.res1 : head.res0;
    assign pop        = bound_accept && (sel_reg == head.two);

    assign c        = cigar_item.cigar_char;
    assign is_digit = (c >= cta_pkg::CH_0) && (c <= cta_pkg::CH_9);
    assign is_match = (c == cta_pkg::CH_M) || (c == cta_pkg::CH_LOWER_M) ||
                      (c == cta_pkg::CH_EQUAL) || (c == cta_pkg::CH_X);
    assign is_gap   = (c == cta_pkg::CH_N) || (c == cta_pkg::CH_D);
    assign is_ins   = (c == cta_pkg::CH_I);
    assign is_star  = (c == cta_pkg::CH_STAR);

    assign acc_wide  = ({4'b0, run_reg} << 3) + ({4'b0, run_reg} << 1)
                     + (PB+4)'(c[3:0]);
    assign run_digit = (acc_wide > (PB+4)'(POS_MAX)) ? POS_MAX : acc_wide[PB-1:0];

    assign sum_wide = {1'b0, held_reg} + {1'b0, run_reg};
    assign sum_sat  = sum_wide[PB] ? POS_MAX : sum_wide[PB-1:0];

    assign start_wide = EW'(cigar_item.start_position);
    assign start_sat  = (start_wide > EW'(POS_MAX)) ? POS_MAX : start_wide[PB-1:0];

    always_comb
    begin
        held_next      = held_reg;
        run_next       = run_reg;
        ins_next       = ins_reg;
        count_next     = count_reg;
        star_next      = star_reg;
        append         = 1'b0;
        push           = 1'b0;
        row_new        = '0;
        held_next_wide = '0;

        if (cigar_item.action == cta_pkg::ACTION_BEGIN)
        begin
            held_next  = start_sat;
            run_next   = '0;
            ins_next   = 1'b0;
            count_next = '0;
            star_next  = 1'b0;
        end
        else
        begin
            if (is_digit)
            begin
                run_next = run_digit;
            end
            else
            begin
                run_next = '0;
                if (is_star)
                begin
                    if (count_reg == '0)
                    begin
                        star_next = 1'b1;
                    end
                end
                else if (!star_reg)
                begin
                    if (is_match)
                    begin
                        if (ins_reg)
                        begin
                            held_next = sum_sat;
                            ins_next  = 1'b0;
                        end
                        else
                        begin
                            append = 1'b1;
                        end
                    end
                    else if (is_gap)
                    begin
                        append = 1'b1;
                    end
                    else if (is_ins)
                    begin
                        ins_next = 1'b1;
                    end
                end
            end

            if (append)
            begin
                held_next  = sum_sat;
                count_next = (count_reg == INDEX_MAX) ? count_reg : count_reg + 1'b1;
            end

            held_next_wide = EW'(held_next);

            row_new.res0.boundary       = held_wide[BB-1:0];
            row_new.res0.boundary_index = count_reg;
            row_new.res0.empty_read     = 1'b0;
            row_new.res0.last           = 1'b0;

            if (cigar_item.end_of_cigar)
            begin
                if (star_next)
                begin
                    row_new.res1.boundary       = '0;
                    row_new.res1.boundary_index = '0;
                    row_new.res1.empty_read     = 1'b1;
                end
                else
                begin
                    row_new.res1.boundary       = held_next_wide[BB-1:0];
                    row_new.res1.boundary_index = count_next;
                    row_new.res1.empty_read     = 1'b0;
                end
                row_new.res1.last = 1'b1;
                if (!append)
                begin
                    row_new.res0 = row_new.res1;
                end
                row_new.two = append;
                held_next   = '0;
                run_next    = '0;
                ins_next    = 1'b0;
                count_next  = '0;
                star_next   = 1'b0;
            end

            push = append || cigar_item.end_of_cigar;
        end
    end

    assign held_wide = EW'(held_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sel_next    = sel_reg;
        fill_next   = fill_reg;
        if (cigar_accept && push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (bound_accept)
        begin
            sel_next = !pop;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        fill_next = fill_reg + 2'(cigar_accept && push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            run_reg    <= '0;
            ins_reg    <= 1'b0;
            count_reg  <= '0;
            star_reg   <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            if (cigar_accept)
            begin
                held_reg  <= held_next;
                run_reg   <= run_next;
                ins_reg   <= ins_next;
                count_reg <= count_next;
                star_reg  <= star_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cigar_accept && push)
        begin
            rows_reg[wr_ptr_reg] <= row_new;
        end
    end

endmodule

// ===== rtl/cta_checker.sv =====
// ----------------------------------------------------------------------------
// CIGAR to aligned boundaries checker
// Port-level checks on the boundary core, attached to every instance by bind.
// ----------------------------------------------------------------------------
module cta_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cigar_valid,
    input logic                 cigar_stall,
    input cta_pkg::cigar_item_t cigar_item,
    input logic                 bound_valid,
    input logic                 bound_stall,
    input cta_pkg::bound_item_t bound_item
);

    logic cigar_accept;

    assign cigar_accept = cigar_valid && !cigar_stall;

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        bound_valid && bound_stall |=> bound_valid && $stable(bound_item))
        else $error("Stalled result changed or was withdrawn.");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        bound_valid && bound_item.empty_read |->
            bound_item.last && (bound_item.boundary == '0) &&
            (bound_item.boundary_index == '0))
        else $error("Empty read result is malformed.");

    a_begin_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cigar_accept && (cigar_item.action == cta_pkg::ACTION_BEGIN) && !bound_valid
            |=> !bound_valid)
        else $error("Begin item produced a result.");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cigar_accept && (cigar_item.action == cta_pkg::ACTION_CHAR) &&
            cigar_item.end_of_cigar && !bound_valid |=> bound_valid)
        else $error("End of CIGAR produced no result.");

endmodule

bind cigar_to_aligned_boundaries_core cta_checker u_cta_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cigar_valid (cigar_valid),
    .cigar_stall (cigar_stall),
    .cigar_item  (cigar_item),
    .bound_valid (bound_valid),
    .bound_stall (bound_stall),
    .bound_item  (bound_item)
);
